>>> rtl/core/jq_pkg.sv
// Package for the job queue: word types, command and status codes, FSM states.
`default_nettype none

package jq_pkg;

    // Field widths fixed by the word formats
    localparam int ID_W     = 16;
    localparam int DOC_W    = 16;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;
    localparam int ENTRY_W  = ID_W + DOC_W;

    // Default queue depth
    localparam int DEPTH_DEF = 16;

    // Command codes
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_SEARCH  = 2'd1;
    localparam logic [1:0] CMD_CANCEL  = 2'd2;
    localparam logic [1:0] CMD_PROCESS = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ID_W-1:0]  job_id;
        logic [DOC_W-1:0] doc_handle;
        logic             high_priority;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [ID_W-1:0]     head_id;
        logic [DOC_W-1:0]    head_doc;
        logic [OCC_W-1:0]    occupancy;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_POP_RD,
        S_POP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/two_level_job_queue_top.sv
// Two-priority job queue with search and cancel, kept in a circular buffer RAM.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one command word:
//   insert, search, cancel or process head. Output channel (o_out_valid /
//   i_out_ready / o_out_word) returns exactly one result word per command.
//   Jobs live in one RAM used as a ring: a high-priority insert writes just
//   ahead of the head pointer, a normal insert just past the tail.
// Command handling:
//   process head reads the head entry; search and insert scan the queued
//   jobs; cancel scans for the job, then moves each job behind the
//   cancelled one forward to close the gap. With the single RAM read port,
//   lookup and gap closing walk the ring one entry per cycle.
//   One command is worked on at a time; o_in_ready is high only when idle.
// Reset: synchronous, active low; empties the queue. RAM contents are not
//   cleared, only entries below the job count are ever read.
// Stall: a finished result waits in the output register; the next command is
//   accepted meanwhile, and its own result waits until that register frees.
`default_nettype none

module two_level_job_queue_top
    import jq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state          r_state, n_state;
    logic [PW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    t_in_word        r_item, n_item;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_pend_idx, n_pend_idx;
    t_out_word       r_res, n_res;
    logic            r_out_valid;
    t_out_word       r_out_word;

    logic                mem_we;
    logic [PW-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [PW-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;
    logic                out_load;
    logic                hit;

    // Logical position to ring address
    function automatic logic [PW-1:0] f_phys(input logic [PW-1:0] head,
                                             input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(pos);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    jq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
        if (out_load) begin
            r_out_word <= {r_res.status, r_res.found, r_res.head_id, r_res.head_doc,
                           OCC_W'(r_count)};
        end
    end

    assign hit = r_pend && (mem_rdata[ENTRY_W-1 -: ID_W] == r_item.job_id);

    // Next state, RAM access and result
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_item     = r_item;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = f_phys(r_head, r_count);
        mem_wdata  = {r_item.job_id, r_item.doc_handle};
        mem_raddr  = f_phys(r_head, r_idx);
        o_in_ready = 1'b0;
        out_load   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item = i_in_word;
                    n_idx  = '0;
                    n_res  = '0;
                    if (i_in_word.cmd == CMD_PROCESS) begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_POP_RD: begin
                mem_raddr = r_head;
                n_state   = S_POP;
            end

            S_POP: begin
                n_res.head_id  = mem_rdata[ENTRY_W-1 -: ID_W];
                n_res.head_doc = mem_rdata[DOC_W-1:0];
                n_head  = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
                n_state = S_DONE;
            end

            S_SCAN: begin
                // issue next read, compare the one in flight
                if (r_idx < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + 1'b1;
                end
                if (hit) begin
                    n_pend = 1'b0;
                    priority case (r_item.cmd)
                        CMD_INSERT: begin
                            n_res.status = ST_DUP;
                            n_state      = S_DONE;
                        end
                        CMD_CANCEL: begin
                            n_idx   = r_pend_idx + 1'b1;
                            n_state = S_SHIFT;
                        end
                        default: begin
                            n_res.found = 1'b1;
                            n_state     = S_DONE;
                        end
                    endcase
                end else if (!r_pend && (r_idx >= r_count)) begin
                    n_state = S_DONE;
                    priority case (r_item.cmd)
                        CMD_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                                if (r_item.high_priority) begin
                                    n_head = (r_head == '0) ? PW'(DEPTH - 1)
                                                            : r_head - 1'b1;
                                    mem_waddr = n_head;
                                end
                            end
                        end
                        CMD_CANCEL: begin
                            n_res.status = ST_NOTFOUND;
                        end
                        default: begin
                            n_res.found = 1'b0;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // read entry k, write it back to k-1 when the registered read data returns
                mem_waddr = f_phys(r_head, r_pend_idx - 1'b1);
                mem_wdata = mem_rdata;
                mem_we    = r_pend;
                if (r_idx < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job count above depth");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_SCAN || r_state == S_SHIFT))
        else $error("RAM write outside insert or shift");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not reduce job count");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_EMPTY) |->
            (o_out_word.occupancy == '0))
        else $error("empty status with jobs queued");

endmodule

`default_nettype wire

>>> rtl/core/jq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module jq_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire
